/* rtl/core/hdrbp_pkg.sv */
// ----------------------------------------------------------------------------
// hdrbp_pkg
// Types, constants and character decode helpers shared by the byte
// specification parser and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package hdrbp_pkg;

  localparam int unsigned DEFAULT_MAX_CAPACITY = 4096;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned STATUS_W = 4;

  localparam logic [LEN_W-1:0] CAPACITY_RESET = 13'd4096;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [7:0] CHAR_STAR     = 8'h2A;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_ONE      = 8'h31;
  localparam logic [7:0] CHAR_EIGHT    = 8'h38;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_A_UP     = 8'h41;
  localparam logic [7:0] CHAR_F_UP     = 8'h46;
  localparam logic [7:0] CHAR_A_LO     = 8'h61;
  localparam logic [7:0] CHAR_F_LO     = 8'h66;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_CR       = 8'h0D;

  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  typedef enum logic [STATUS_W-1:0] {
    STAT_RUN           = 4'd0,
    STAT_COMPLETE      = 4'd1,
    STAT_BAD_HEX       = 4'd2,
    STAT_BAD_DOT       = 4'd3,
    STAT_DUP_DOT       = 4'd4,
    STAT_BAD_DIGIT     = 4'd5,
    STAT_LEADING_ZERO  = 4'd6,
    STAT_MISSING_COUNT = 4'd7,
    STAT_TOO_SMALL     = 4'd8,
    STAT_INCOMPLETE    = 4'd9
  } hdrbp_status_e;

  typedef enum logic [5:0] {
    PH_NEXT  = 6'b000001,
    PH_HEX   = 6'b000010,
    PH_DOTS  = 6'b000100,
    PH_AFTER = 6'b001000,
    PH_COUNT = 6'b010000,
    PH_ERROR = 6'b100000
  } hdrbp_phase_e;

  typedef struct packed {
    hdrbp_status_e      status;
    logic [CHAR_W-1:0]  byte_value;
    logic [LEN_W-1:0]   repeat_res;
    logic [LEN_W-1:0]   total_length;
    logic               string_done;
    logic               last_of_item;
  } hdrbp_res_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // Returns {valid, value}.
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [7:0] diff;
    logic [4:0] r;
    r = '0;
    if ((c >= CHAR_ZERO) && (c <= CHAR_NINE)) begin
      diff = c - CHAR_ZERO;
      r = {1'b1, diff[3:0]};
    end else if ((c >= CHAR_A_UP) && (c <= CHAR_F_UP)) begin
      diff = c - CHAR_A_UP;
      r = {1'b1, diff[3:0] + HEX_LETTER_BASE};
    end else if ((c >= CHAR_A_LO) && (c <= CHAR_F_LO)) begin
      diff = c - CHAR_A_LO;
      r = {1'b1, diff[3:0] + HEX_LETTER_BASE};
    end
    return r;
  endfunction

  function automatic hdrbp_res_t mk_run(logic [CHAR_W-1:0] value, logic [LEN_W-1:0] rep,
                                        logic [LEN_W-1:0] total);
    hdrbp_res_t r;
    r.status       = STAT_RUN;
    r.byte_value   = value;
    r.repeat_res   = rep;
    r.total_length = total;
    r.string_done  = 1'b0;
    r.last_of_item = 1'b0;
    return r;
  endfunction

  function automatic hdrbp_res_t mk_end(hdrbp_status_e st, logic [LEN_W-1:0] total);
    hdrbp_res_t r;
    r.status       = st;
    r.byte_value   = '0;
    r.repeat_res   = '0;
    r.total_length = total;
    r.string_done  = 1'b1;
    r.last_of_item = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hdrbp_parser.sv */
// ----------------------------------------------------------------------------
// hdrbp_parser
// Parse state and one-character decode; yields up to two results per request.
// ----------------------------------------------------------------------------
`default_nettype none

module hdrbp_parser
  import hdrbp_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = DEFAULT_MAX_CAPACITY
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 take_i,
  input  wire logic [CHAR_W-1:0]    character_i,
  input  wire logic                 end_marker_i,
  input  wire logic [LEN_W-1:0]     capacity_i,
  output hdrbp_res_t [1:0]          res_o,
  output logic [1:0]                res_cnt_o
);

  localparam int unsigned SAT_COUNT = MAX_CAPACITY + 1;
  localparam int unsigned CW = $clog2(MAX_CAPACITY + 2);
  localparam int unsigned SW = ((CW > LEN_W) ? CW : LEN_W) + 1;
  localparam int unsigned PW = CW + 4;

  hdrbp_phase_e      phase_q, phase_d, ph;
  logic [CHAR_W-1:0] byte_q, byte_d;
  logic [CW-1:0]     count_q, count_d;
  logic [LEN_W-1:0]  emitted_q, emitted_d;

  logic [SW-1:0]     sum, cap_w, max_w, cap_eff;
  logic              too_small;
  logic [4:0]        hex;
  logic [2:0]        dot_idx;
  logic [7:0]        dot_bit;
  logic [7:0]        digit;
  logic [PW-1:0]     cnt_ext, cnt_mul;
  logic [CW-1:0]     cnt_sat;
  logic [LEN_W-1:0]  base_total, sum_len;
  logic [LEN_W-1:0]  count_len;
  hdrbp_res_t [1:0]  res;
  logic [1:0]        n;

  always_comb begin
    sum       = SW'(emitted_q) + SW'(count_q);
    cap_w     = SW'(capacity_i);
    max_w     = SW'(MAX_CAPACITY);
    cap_eff   = (cap_w > max_w) ? max_w : cap_w;
    too_small = sum > cap_eff;
    sum_len   = LEN_W'(sum);
    count_len = LEN_W'(count_q);
    hex       = hex_decode(character_i);
    dot_idx   = 3'(character_i - CHAR_ONE);
    dot_bit   = 8'(1) << dot_idx;
    digit     = character_i - CHAR_ZERO;
    cnt_ext   = PW'(count_q);
    cnt_mul   = (cnt_ext << 3) + (cnt_ext << 1) + PW'(digit[3:0]);
    cnt_sat   = (cnt_mul > PW'(SAT_COUNT)) ? CW'(SAT_COUNT) : CW'(cnt_mul);
  end

  always_comb begin
    phase_d    = phase_q;
    byte_d     = byte_q;
    count_d    = count_q;
    emitted_d  = emitted_q;
    res        = '0;
    n          = '0;
    ph         = phase_q;
    base_total = emitted_q;

    if (end_marker_i) begin
      case (phase_q)
        PH_NEXT: begin
          res[0] = mk_end(STAT_COMPLETE, emitted_q);
          n      = 2'd1;
        end
        PH_HEX, PH_DOTS: begin
          res[0] = mk_end(STAT_INCOMPLETE, emitted_q);
          n      = 2'd1;
        end
        PH_AFTER, PH_COUNT: begin
          if ((phase_q == PH_COUNT) && (count_q == '0)) begin
            res[0] = mk_end(STAT_INCOMPLETE, emitted_q);
            n      = 2'd1;
          end else if (too_small) begin
            res[0] = mk_end(STAT_TOO_SMALL, emitted_q);
            n      = 2'd1;
          end else begin
            res[0] = mk_run(byte_q, count_len, sum_len);
            res[1] = mk_end(STAT_COMPLETE, sum_len);
            n      = 2'd2;
          end
        end
        default: begin
        end
      endcase
      phase_d   = PH_NEXT;
      byte_d    = '0;
      count_d   = CW'(1);
      emitted_d = '0;
    end else begin
      // A finished byte is flushed by any character other than the repeat mark.
      if (phase_q == PH_AFTER) begin
        if (character_i == CHAR_STAR) begin
          phase_d = PH_COUNT;
          count_d = '0;
          ph      = PH_ERROR;
        end else if (too_small) begin
          res[0]  = mk_end(STAT_TOO_SMALL, emitted_q);
          n       = 2'd1;
          phase_d = PH_ERROR;
          ph      = PH_ERROR;
        end else begin
          res[0]     = mk_run(byte_q, count_len, sum_len);
          n          = 2'd1;
          emitted_d  = sum_len;
          byte_d     = '0;
          count_d    = CW'(1);
          base_total = sum_len;
          phase_d    = PH_NEXT;
          ph         = PH_NEXT;
        end
      end

      case (ph)
        PH_NEXT: begin
          if (is_space(character_i)) begin
          end else if (character_i == CHAR_LBRACKET) begin
            byte_d  = '0;
            phase_d = PH_DOTS;
          end else if (hex[4]) begin
            byte_d  = {hex[3:0], 4'b0000};
            phase_d = PH_HEX;
          end else begin
            res[n[0]] = mk_end(STAT_BAD_HEX, base_total);
            n         = n + 2'd1;
            phase_d   = PH_ERROR;
          end
        end
        PH_HEX: begin
          if (hex[4]) begin
            byte_d  = byte_q | {4'b0000, hex[3:0]};
            phase_d = PH_AFTER;
          end else begin
            res[0]  = mk_end(STAT_BAD_HEX, emitted_q);
            n       = 2'd1;
            phase_d = PH_ERROR;
          end
        end
        PH_DOTS: begin
          if (character_i == CHAR_RBRACKET) begin
            phase_d = PH_AFTER;
          end else if ((character_i < CHAR_ONE) || (character_i > CHAR_EIGHT)) begin
            res[0]  = mk_end(STAT_BAD_DOT, emitted_q);
            n       = 2'd1;
            phase_d = PH_ERROR;
          end else if ((byte_q & dot_bit) != '0) begin
            res[0]  = mk_end(STAT_DUP_DOT, emitted_q);
            n       = 2'd1;
            phase_d = PH_ERROR;
          end else begin
            byte_d = byte_q | dot_bit;
          end
        end
        PH_COUNT: begin
          if (is_space(character_i)) begin
            if (count_q == '0) begin
              res[0]  = mk_end(STAT_MISSING_COUNT, emitted_q);
              n       = 2'd1;
              phase_d = PH_ERROR;
            end else if (too_small) begin
              res[0]  = mk_end(STAT_TOO_SMALL, emitted_q);
              n       = 2'd1;
              phase_d = PH_ERROR;
            end else begin
              res[0]    = mk_run(byte_q, count_len, sum_len);
              n         = 2'd1;
              emitted_d = sum_len;
              byte_d    = '0;
              count_d   = CW'(1);
              phase_d   = PH_NEXT;
            end
          end else if ((character_i < CHAR_ZERO) || (character_i > CHAR_NINE)) begin
            res[0]  = mk_end(STAT_BAD_DIGIT, emitted_q);
            n       = 2'd1;
            phase_d = PH_ERROR;
          end else if ((character_i == CHAR_ZERO) && (count_q == '0)) begin
            res[0]  = mk_end(STAT_LEADING_ZERO, emitted_q);
            n       = 2'd1;
            phase_d = PH_ERROR;
          end else begin
            count_d = cnt_sat;
          end
        end
        default: begin
        end
      endcase
    end

    res[0].last_of_item = (n == 2'd1);
    res[1].last_of_item = 1'b1;
  end

  assign res_o     = res;
  assign res_cnt_o = take_i ? n : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_NEXT;
      byte_q    <= '0;
      count_q   <= CW'(1);
      emitted_q <= '0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      byte_q    <= byte_d;
      count_q   <= count_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hex_dot_repeat_byte_parser.sv */
// ----------------------------------------------------------------------------
// hex_dot_repeat_byte_parser
// Streaming parser of hex and dot-pattern byte specifications with repeats.
// ----------------------------------------------------------------------------
// Each input request carries one character or an end-of-string marker and is
// decoded in the cycle it is accepted; its zero, one or two results enter a
// four-entry output queue. Input is taken every cycle while the queue has two
// free entries, so a stream whose requests give at most one result each runs
// at one request per cycle; the output delivers one result per cycle while
// m_axis_tready is high, and a request with two results fills two entries.
// A byte's run appears with the character after it or with the end marker.
`default_nettype none

module hex_dot_repeat_byte_parser
  import hdrbp_pkg::*;
#(
  parameter int unsigned MAX_CAPACITY = DEFAULT_MAX_CAPACITY
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Character stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] character
  input  wire logic        s_axis_tuser,  // [0] end_marker
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,  // [7:0] byte_value, [20:8] repeat_res,
                                          // [33:21] total_length, [39:34] zero
  output logic      [4:0]  m_axis_tuser,  // [3:0] status, [4] string_done
  output logic             m_axis_tlast   // last_of_item
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [LEN_W-1:0] capacity_q;
  logic             cfg_write;
  logic             take;
  logic             pop;

  hdrbp_res_t [1:0] res;
  logic [1:0]       res_cnt;

  hdrbp_res_t       fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  hdrbp_res_t       head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? 32'(capacity_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity_q <= pwdata[LEN_W-1:0];
    end
  end

  assign s_axis_tready = cnt_q <= CNT_W'(FIFO_DEPTH - 2);
  assign take          = s_axis_tvalid && s_axis_tready;

  hdrbp_parser #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .character_i  (s_axis_tdata),
    .end_marker_i (s_axis_tuser),
    .capacity_i   (capacity_q),
    .res_o        (res),
    .res_cnt_o    (res_cnt)
  );

  assign m_axis_tvalid = cnt_q != '0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign head          = fifo_q[rptr_q];

  assign m_axis_tdata = {6'b000000, head.total_length, head.repeat_res, head.byte_value};
  assign m_axis_tuser = {head.string_done, head.status};
  assign m_axis_tlast = head.last_of_item;

  always_ff @(posedge clk_i) begin
    if (res_cnt != 2'd0) begin
      fifo_q[wptr_q] <= res[0];
    end
    if (res_cnt == 2'd2) begin
      fifo_q[wptr_q + PTR_W'(1)] <= res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + PTR_W'(res_cnt);
      if (pop) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(res_cnt) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire
